// ----- sv/tmdp_pkg.sv -----
// shared types, constants and codes for the trace mean difference peak unit
package tmdp_pkg;

  localparam int TRACE_DEPTH = 4096;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int SAMPLE_W = 41;
  localparam int COUNT_W  = 16;
  localparam int DIFF_W   = 17;
  localparam int PEAK_W   = 17;

  // an index never reaches past 2^INDEX_W - 1, so the store needs no more rows
  localparam int MEM_DEPTH = (TRACE_DEPTH < (1 << INDEX_W)) ? TRACE_DEPTH : (1 << INDEX_W);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // divider works on a padded dividend, two quotient bits per cycle
  localparam int DIV_BITS  = SAMPLE_W + 1;
  localparam int DIV_STEPS = DIV_BITS / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCUM = 2'd0,
    ACT_DIFF  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ACCUM,
    S_DIV_OWN,
    S_WAIT_OWN,
    S_DIV_OTHER,
    S_WAIT_OTHER,
    S_FINISH,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic mem_read;
    logic accum_write;
    logic sweep_write;
    logic div_start;
    logic div_sel_other;
    logic keep_own;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    div_busy;
    logic    sweep_end;
    logic    out_free;
  } stat_t;

endpackage

// ----- sv/tmdp_divider.sv -----
// iterative signed-by-unsigned divider, truncating toward zero, zero divisor gives zero
module tmdp_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [tmdp_pkg::SAMPLE_W-1:0] dividend,
  input  logic        [tmdp_pkg::COUNT_W-1:0]  divisor,
  output logic                                 busy,
  output logic signed [tmdp_pkg::SAMPLE_W-1:0] quotient
);
  import tmdp_pkg::*;

  logic [DIV_BITS-1:0] work;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W-1:0]  dvs;
  logic                neg;
  logic                dvs_zero;
  logic [STEP_W-1:0]   steps;

  logic [COUNT_W:0]    r1, r2;
  logic                ge1, ge2;
  logic [COUNT_W:0]    r1s, r2s;
  logic [DIV_BITS-1:0] w1, w2;
  logic [SAMPLE_W-1:0] mag_in;

  assign mag_in = dividend[SAMPLE_W-1] ? SAMPLE_W'(-dividend) : dividend;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem, work[DIV_BITS-1]};
    ge1 = (r1 >= {1'b0, dvs});
    r1s = ge1 ? (r1 - {1'b0, dvs}) : r1;
    w1  = {work[DIV_BITS-2:0], ge1};
    r2  = {r1s[COUNT_W-1:0], w1[DIV_BITS-1]};
    ge2 = (r2 >= {1'b0, dvs});
    r2s = ge2 ? (r2 - {1'b0, dvs}) : r2;
    w2  = {w1[DIV_BITS-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work     <= {1'b0, mag_in};
      rem      <= '0;
      dvs      <= divisor;
      neg      <= dividend[SAMPLE_W-1];
      dvs_zero <= (divisor == '0);
    end else if (busy) begin
      work <= w2;
      rem  <= r2s[COUNT_W-1:0];
    end
  end

  assign busy = (steps != '0);

  always_comb begin
    if (dvs_zero) begin
      quotient = '0;
    end else if (neg) begin
      quotient = SAMPLE_W'(-work[SAMPLE_W-1:0]);
    end else begin
      quotient = work[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- sv/tmdp_datapath.sv -----
// datapath: item registers, sum store, trace count, divider, peak and output register
module tmdp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmdp_pkg::cmd_t                       cmd,
  output tmdp_pkg::stat_t                      stat,
  input  logic [tmdp_pkg::IN_DATA_W-1:0]       in_data,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tmdp_pkg::DIFF_W-1:0]   out_diff,
  output logic        [tmdp_pkg::PEAK_W-1:0]   out_peak,
  output logic                                 out_last
);
  import tmdp_pkg::*;

  // latched item
  action_t                    item_action;
  logic [INDEX_W-1:0]         item_index;
  logic signed [SAMPLE_W-1:0] item_value;
  logic [COUNT_W-1:0]         item_count;
  logic                       item_last;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [ADDR_W-1:0]          sweep_addr;
  logic [ADDR_W-1:0]          item_addr;
  logic                       in_range;

  logic [COUNT_W-1:0]         traces_summed;
  logic [PEAK_W-1:0]          running_peak;
  logic signed [SAMPLE_W-1:0] own_mean;
  logic signed [DIFF_W-1:0]   diff;

  logic signed [SAMPLE_W:0]   acc_full;
  logic signed [SAMPLE_W-1:0] acc_sat;
  logic [COUNT_W:0]           cnt_full;
  logic [COUNT_W-1:0]         cnt_sat;
  logic signed [SAMPLE_W-1:0] own_sum;
  logic signed [SAMPLE_W-1:0] div_a;
  logic [COUNT_W-1:0]         div_b;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_q;
  logic signed [SAMPLE_W:0]   diff_full;
  logic signed [DIFF_W-1:0]   diff_sat;
  logic [PEAK_W-1:0]          mag;
  logic [PEAK_W-1:0]          peak_new;

  assign in_range  = ({5'd0, item_index} < 17'(TRACE_DEPTH));
  assign item_addr = item_index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_action <= action_t'(in_data[1:0]);
      item_index  <= in_data[13:2];
      item_value  <= in_data[54:14];
      item_count  <= in_data[70:55];
      item_last   <= in_last;
    end
  end

  // saturating slot add
  always_comb begin
    acc_full = {rd_data[SAMPLE_W-1], rd_data} + {item_value[SAMPLE_W-1], item_value};
    if (acc_full[SAMPLE_W] != acc_full[SAMPLE_W-1]) begin
      acc_sat = acc_full[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      acc_sat = acc_full[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    cnt_full = {1'b0, traces_summed} + {1'b0, item_count};
    cnt_sat  = cnt_full[COUNT_W] ? {COUNT_W{1'b1}} : cnt_full[COUNT_W-1:0];
  end

  // sum store, registered read
  always_ff @(posedge clk) begin
    if (cmd.sweep_write) begin
      mem[sweep_addr] <= '0;
    end else if (cmd.accum_write && in_range) begin
      mem[item_addr] <= acc_sat;
    end
    if (cmd.mem_read) begin
      rd_data <= mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_write) begin
      sweep_addr <= stat.sweep_end ? '0 : sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      traces_summed <= '0;
    end else if (cmd.sweep_write) begin
      traces_summed <= '0;
    end else if (cmd.accum_write && item_last) begin
      traces_summed <= cnt_sat;
    end
  end

  assign own_sum = in_range ? rd_data : '0;
  assign div_a   = cmd.div_sel_other ? item_value : own_sum;
  assign div_b   = cmd.div_sel_other ? item_count : traces_summed;

  tmdp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.keep_own) begin
      own_mean <= div_q;
    end
  end

  // own mean minus other mean, clamped to the result range
  always_comb begin
    diff_full = {own_mean[SAMPLE_W-1], own_mean} - {div_q[SAMPLE_W-1], div_q};
    if (diff_full[SAMPLE_W:DIFF_W-1] == '0 || diff_full[SAMPLE_W:DIFF_W-1] == '1) begin
      diff_sat = diff_full[DIFF_W-1:0];
    end else if (diff_full[SAMPLE_W]) begin
      diff_sat = {1'b1, {(DIFF_W-1){1'b0}}};
    end else begin
      diff_sat = {1'b0, {(DIFF_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff <= '0;
    end else if (cmd.finish) begin
      diff <= diff_sat;
    end
  end

  assign mag      = diff[DIFF_W-1] ? PEAK_W'(-diff) : PEAK_W'(diff);
  assign peak_new = (mag > running_peak) ? mag : running_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
    end else if (cmd.load_out) begin
      running_peak <= item_last ? '0 : peak_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_diff <= diff;
      out_peak <= peak_new;
      out_last <= item_last;
    end
  end

  always_comb begin
    stat.action    = item_action;
    stat.div_busy  = div_busy;
    stat.sweep_end = (sweep_addr == ADDR_W'(MEM_DEPTH - 1));
    stat.out_free  = !out_valid || out_ready;
  end

  a_peak_restarts: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && item_last) |=> (running_peak == '0))
    else $error("peak not cleared after run end");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_write |=> (traces_summed == '0))
    else $error("trace count not cleared by sweep");

  a_peak_covers_diff: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (out_peak >= $past(mag)))
    else $error("peak below its own difference");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_busy)
    else $error("divider did not start");

endmodule

// ----- sv/tmdp_controller.sv -----
// controller state machine sequencing the datapath
module tmdp_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmdp_pkg::stat_t stat,
  output tmdp_pkg::cmd_t  cmd
);
  import tmdp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:       if (stat.sweep_end) state_next = S_IDLE;
      S_IDLE:       if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (stat.action)
          ACT_ACCUM: state_next = S_ACCUM;
          ACT_DIFF:  state_next = S_DIV_OWN;
          ACT_CLEAR: state_next = S_CLEAR;
          ACT_NONE:  state_next = S_DONE;
        endcase
      end
      S_ACCUM:      state_next = S_DONE;
      S_DIV_OWN:    state_next = S_WAIT_OWN;
      S_WAIT_OWN:   if (!stat.div_busy) state_next = S_DIV_OTHER;
      S_DIV_OTHER:  state_next = S_WAIT_OTHER;
      S_WAIT_OTHER: if (!stat.div_busy) state_next = S_FINISH;
      S_FINISH:     state_next = S_DONE;
      S_CLEAR:      if (stat.sweep_end) state_next = S_DONE;
      S_DONE:       if (stat.out_free) state_next = S_IDLE;
      default:      state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT:       cmd.sweep_write = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DECODE:     cmd.mem_read = 1'b1;
      S_ACCUM:      cmd.accum_write = 1'b1;
      S_DIV_OWN:    cmd.div_start = 1'b1;
      S_WAIT_OWN:   cmd.keep_own = !stat.div_busy;
      S_DIV_OTHER: begin
        cmd.div_start     = 1'b1;
        cmd.div_sel_other = 1'b1;
      end
      S_WAIT_OTHER: cmd.div_sel_other = 1'b1;
      S_FINISH:     cmd.finish = 1'b1;
      S_CLEAR:      cmd.sweep_write = 1'b1;
      S_DONE:       cmd.load_out = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ----- sv/trace_mean_difference_peak_unit.sv -----
// top level of the trace mean difference peak unit
// accept to output valid: decode, then accumulate writes its slot, differential runs
//   two divider passes and a finish step, clear zeroes all MEM_DEPTH rows, an unused
//   action does nothing; then the result loads
// one item at a time; the next is taken after the result loads, even while it waits
// reset: synchronous, then a zeroing pass over all MEM_DEPTH rows before the first item
module trace_mean_difference_peak_unit (
  input  logic                               clk,
  input  logic                               rst,
  // item in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // action[1:0], sample_index[13:2], sample_value[54:14], trace_count_in[70:55], zero pad
  input  logic [tmdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // run_last
  input  logic                               s_axis_tlast,
  // result out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mean_difference[16:0], peak_magnitude[33:17], zero pad
  output logic [tmdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // result_last
  output logic                               m_axis_tlast
);
  import tmdp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic signed [DIFF_W-1:0] out_diff;
  logic        [PEAK_W-1:0] out_peak;

  // sequencing: sweep, decode, accumulate or two divisions, result hand-off
  tmdp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // sums, counts, divider and output register
  tmdp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_diff  (out_diff),
    .out_peak  (out_peak),
    .out_last  (m_axis_tlast)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {{(OUT_DATA_W - DIFF_W - PEAK_W){1'b0}}, out_peak, out_diff};

endmodule

// ----- tb/tb_trace_mean_difference_peak_unit.sv -----
// self-checking testbench for the trace mean difference peak unit: directed and random items
module tb_trace_mean_difference_peak_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tmdp_pkg::*;

  // one input item as the block sees it
  typedef struct packed {
    action_t                     action;
    logic [INDEX_W-1:0]          index;
    logic signed [SAMPLE_W-1:0]  value;
    logic [COUNT_W-1:0]          count;
    logic                        last;
  } trace_item_t;

  // one result item
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [PEAK_W-1:0]        peak;
    logic                     last;
  } mean_result_t;

  localparam longint SUM_TOP    = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SUM_BOTTOM = -(64'sd1 <<< (SAMPLE_W - 1));
  localparam longint DIFF_TOP    = (64'sd1 <<< (DIFF_W - 1)) - 1;
  localparam longint DIFF_BOTTOM = -(64'sd1 <<< (DIFF_W - 1));
  localparam int unsigned COUNT_TOP = (1 << COUNT_W) - 1;
  localparam int RANDOM_ITEMS = 1200;
  // longest block latency is a clear sweep over the whole store
  localparam int DRAIN_CYCLES = MEM_DEPTH + 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;

  trace_item_t  pending_items[$];
  mean_result_t expected_results[$];
  trace_item_t  item_on_bus = '0;
  mean_result_t oldest_result;
  int           items_taken = 0;
  int           error_count = 0;

  // predictor state: sum per sample slot, traces summed, peak of the current run
  longint       slot_sums[TRACE_DEPTH];
  int unsigned  trace_total = 0;
  logic [PEAK_W-1:0] peak_so_far = '0;

  trace_mean_difference_peak_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mean with truncation toward zero, zero count gives zero
  function automatic longint mean_of_sum(longint sum, int unsigned count);
    if (count == 0) return 0;
    return sum / longint'(count);
  endfunction

  // advance the predictor by one item and return the result it causes
  function automatic mean_result_t predict_mean_difference(trace_item_t it);
    mean_result_t r;
    longint       s;
    longint       own;
    longint       d;
    int unsigned  c;
    d = 0;
    case (it.action)
      ACT_ACCUM: begin
        if (it.index < TRACE_DEPTH) begin
          s = slot_sums[it.index] + longint'(it.value);
          if (s > SUM_TOP) s = SUM_TOP;
          if (s < SUM_BOTTOM) s = SUM_BOTTOM;
          slot_sums[it.index] = s;
        end
        // trace count only lands on the last item of a pass
        if (it.last) begin
          c = trace_total + it.count;
          trace_total = (c > COUNT_TOP) ? COUNT_TOP : c;
        end
      end
      ACT_DIFF: begin
        own = (it.index < TRACE_DEPTH) ? slot_sums[it.index] : 0;
        d = mean_of_sum(own, trace_total) - mean_of_sum(longint'(it.value), it.count);
        if (d > DIFF_TOP) d = DIFF_TOP;
        if (d < DIFF_BOTTOM) d = DIFF_BOTTOM;
        if (((d < 0) ? -d : d) > longint'(peak_so_far))
          peak_so_far = PEAK_W'((d < 0) ? -d : d);
      end
      ACT_CLEAR: begin
        foreach (slot_sums[i]) slot_sums[i] = 0;
        trace_total = 0;
      end
      default: ;
    endcase
    r.diff = DIFF_W'(d);
    r.peak = peak_so_far;
    r.last = it.last;
    // run ends here for every action
    if (it.last) peak_so_far = '0;
    return r;
  endfunction

  task automatic add_item(action_t a, int unsigned idx, longint val, int unsigned cnt, bit last);
    trace_item_t it;
    it.action = a;
    it.index  = INDEX_W'(idx);
    it.value  = SAMPLE_W'(val);
    it.count  = COUNT_W'(cnt);
    it.last   = last;
    pending_items.push_back(it);
  endtask

  // mostly modest samples, some mid sized, some over the full 41 bits
  function automatic longint pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return longint'($urandom_range(0, 131071)) - 65536;
    if (r < 90) return longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
    return longint'({$urandom, $urandom});
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(0, 255);
    return $urandom_range(0, COUNT_TOP);
  endfunction

  // idling phases rotate every hundred items: none, sender, receiver, both
  function automatic int unsigned sender_idle_pct();
    case ((items_taken / 100) % 4)
      1: return 53;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case ((items_taken / 100) % 4)
      2: return 53;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  // driver: holds an item until taken, predicts its result at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_mean_difference(item_on_bus));
        items_taken <= items_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          item_on_bus   <= pending_items[0];
          s_axis_tdata  <= {{(IN_DATA_W - ACTION_W - INDEX_W - SAMPLE_W - COUNT_W){1'b0}},
                            pending_items[0].count, pending_items[0].value,
                            pending_items[0].index, pending_items[0].action};
          s_axis_tlast  <= pending_items[0].last;
          s_axis_tvalid <= 1'b1;
          pending_items.delete(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back pressure, each taken result checked against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result diff %0d peak %0d last %0b", $time,
                   $signed(m_axis_tdata[DIFF_W-1:0]), m_axis_tdata[DIFF_W +: PEAK_W],
                   m_axis_tlast);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (m_axis_tdata[DIFF_W-1:0] !== oldest_result.diff) begin
            $display("%0t: mean_difference expected %0d actual %0d", $time,
                     oldest_result.diff, $signed(m_axis_tdata[DIFF_W-1:0]));
            error_count++;
          end
          if (m_axis_tdata[DIFF_W +: PEAK_W] !== oldest_result.peak) begin
            $display("%0t: peak_magnitude expected %0d actual %0d", $time,
                     oldest_result.peak, m_axis_tdata[DIFF_W +: PEAK_W]);
            error_count++;
          end
          if (m_axis_tlast !== oldest_result.last) begin
            $display("%0t: result_last expected %0b actual %0b", $time,
                     oldest_result.last, m_axis_tlast);
            error_count++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned base;
    int unsigned width;
    int unsigned passes;
    action_t     a;
    foreach (slot_sums[i]) slot_sums[i] = 0;

    // directed: zero counts, saturation at both ends, count saturation, unused action, clear
    add_item(ACT_DIFF, 0, 1000, 0, 0);
    add_item(ACT_ACCUM, 0, SUM_TOP, 0, 0);
    add_item(ACT_ACCUM, 0, SUM_TOP, 0, 0);
    add_item(ACT_ACCUM, 4095, SUM_BOTTOM, COUNT_TOP, 0);
    add_item(ACT_ACCUM, 4095, SUM_BOTTOM, 0, 0);
    add_item(ACT_ACCUM, 1, 256 * 100, COUNT_TOP, 1);
    add_item(ACT_ACCUM, 2, 5, 7, 1);
    add_item(ACT_DIFF, 0, 0, 1, 0);
    add_item(ACT_DIFF, 4095, 0, 0, 0);
    add_item(ACT_DIFF, 1, SUM_BOTTOM, 1, 1);
    add_item(ACT_NONE, 5, SUM_TOP, COUNT_TOP, 0);
    add_item(ACT_NONE, 4095, -1, 3, 1);
    add_item(ACT_CLEAR, 0, 0, 0, 0);
    add_item(ACT_DIFF, 0, 256 * 3, 1, 0);
    add_item(ACT_ACCUM, 3, -12345, 3, 1);
    add_item(ACT_DIFF, 3, -100, 2, 0);
    add_item(ACT_DIFF, 3, 7, COUNT_TOP, 1);
    add_item(ACT_CLEAR, 4095, SUM_TOP, COUNT_TOP, 1);
    add_item(ACT_ACCUM, 10, -7, 2, 1);
    add_item(ACT_DIFF, 10, 7, 2, 0);
    add_item(ACT_DIFF, 10, SUM_TOP, 1, 0);
    add_item(ACT_DIFF, 10, SUM_BOTTOM, 1, 1);

    // random: mostly campaigns of accumulate passes followed by a differential run
    while (pending_items.size() < RANDOM_ITEMS + 22) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 5) == 0)
          add_item(ACT_CLEAR, $urandom_range(0, 4095), pick_sample(), pick_count(),
                   $urandom_range(0, 1));
        base   = $urandom_range(0, 4095);
        width  = $urandom_range(1, 8);
        passes = $urandom_range(1, 4);
        for (int p = 0; p < passes; p++)
          for (int k = 0; k < width; k++)
            add_item(ACT_ACCUM, (base + k) % 4096, pick_sample(), pick_count(),
                     k == width - 1);
        for (int k = 0; k < width; k++)
          add_item(ACT_DIFF, (base + k) % 4096, pick_sample(), pick_count(), k == width - 1);
      end else begin
        // noise: any action, clears kept rare since each sweeps the whole store
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          a = action_t'($urandom_range(0, 3));
          if (a == ACT_CLEAR && $urandom_range(0, 3) != 0) a = ACT_NONE;
          add_item(a, $urandom_range(0, 4095), longint'({$urandom, $urandom}),
                   $urandom_range(0, COUNT_TOP), $urandom_range(0, 1));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #15_000_000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
